@@ rtl/pfe_pkg.sv @@
// Shared types, letter codes and the sequencer state list of the Playfair encryptor.
// No dependencies; imported by every other file in rtl.
`timescale 1ns / 1ps

package pfe_pkg;

    localparam int unsigned SIDE  = 5;
    localparam int unsigned CELLS = SIDE * SIDE;
    localparam int unsigned ALPHA = 26;

    typedef logic [4:0] t_letter;
    typedef logic [4:0] t_cell;

    localparam t_letter LETTER_I    = 5'd8;
    localparam t_letter LETTER_J    = 5'd9;
    localparam t_letter LETTER_X    = 5'd23;
    localparam t_letter LAST_LETTER = 5'd25;
    localparam t_letter SPACE_CODE  = 5'd26;

    typedef enum logic [2:0] {
        OP_KEY_START   = 3'd0,
        OP_KEY_LETTER  = 3'd1,
        OP_KEY_END     = 3'd2,
        OP_TEXT_LETTER = 3'd3,
        OP_TEXT_END    = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_POS_A,
        S_POS_B,
        S_POS_W,
        S_MAP,
        S_E1,
        S_E1_W,
        S_E2,
        S_E2_W
    } t_state;

    // requests from the sequencer to the key square
    typedef struct packed {
        logic    clear;
        logic    put;
        t_letter put_letter;
        t_cell   rd_addr;
    } t_sq_req;

    function automatic t_letter fold_j(input t_letter c);
        return (c == LETTER_J) ? LETTER_I : c;
    endfunction

endpackage

@@ rtl/pfe_square.sv @@
// Key square store: cell-to-letter and letter-to-cell memories, placed flags, fill count.
// Depends on pfe_pkg. One write (placement) and one registered read per cycle.
`timescale 1ns / 1ps

module pfe_square
    import pfe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sq_req i_req,
    output t_cell   o_pos_q,
    output t_letter o_sq_q
);

    t_letter          r_sq_mem  [CELLS];
    t_cell            r_pos_mem [ALPHA];
    logic [ALPHA-1:0] r_placed;
    logic [ALPHA-1:0] n_placed;
    logic [4:0]       r_fill;
    logic [4:0]       n_fill;
    t_cell            r_pos_q;
    t_letter          r_sq_q;
    logic             do_put;

    assign do_put = i_req.put && !r_placed[i_req.put_letter] && (r_fill < 5'(CELLS));

    always_comb begin
        n_placed = r_placed;
        n_fill   = r_fill;
        if (i_req.clear) begin
            n_placed = '0;
            n_fill   = '0;
        end else if (do_put) begin
            n_placed[i_req.put_letter] = 1'b1;
            n_fill                     = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed <= '0;
            r_fill   <= '0;
        end else begin
            r_placed <= n_placed;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_put && !i_req.clear) begin
            r_sq_mem[r_fill]              <= i_req.put_letter;
            r_pos_mem[i_req.put_letter]   <= r_fill;
        end
        if (i_req.rd_addr < 5'(ALPHA)) begin
            r_pos_q <= r_pos_mem[i_req.rd_addr];
        end
        if (i_req.rd_addr < 5'(CELLS)) begin
            r_sq_q <= r_sq_mem[i_req.rd_addr];
        end
    end

    assign o_pos_q = r_pos_q;
    assign o_sq_q  = r_sq_q;

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(CELLS))
        else $error("fill count beyond square size");

    a_fill_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_placed) == int'(r_fill))
        else $error("placed flags disagree with fill count");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 5'(CELLS) && !i_req.clear) |=> r_fill == 5'(CELLS))
        else $error("full square took another letter");
`endif

endmodule

@@ rtl/pfe_pair_map.sv @@
// Playfair cell mapping: two cells in, two encrypted cells out (row, column, rectangle rules).
// Depends on pfe_pkg. Purely combinational; registered by the sequencer.
`timescale 1ns / 1ps

module pfe_pair_map
    import pfe_pkg::*;
(
    input  t_cell i_pa,
    input  t_cell i_pb,
    output t_cell o_e1,
    output t_cell o_e2
);

    function automatic logic [2:0] row_of(input t_cell p);
        if (p >= 5'd20) return 3'd4;
        else if (p >= 5'd15) return 3'd3;
        else if (p >= 5'd10) return 3'd2;
        else if (p >= 5'd5) return 3'd1;
        else return 3'd0;
    endfunction

    function automatic t_cell row_base(input logic [2:0] r);
        return {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic logic [2:0] step5(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    t_cell      pa;
    t_cell      pb;
    logic [2:0] r1;
    logic [2:0] r2;
    logic [2:0] c1;
    logic [2:0] c2;
    t_cell      c1_full;
    t_cell      c2_full;

    // out-of-range positions clamp to the first cell
    assign pa = (i_pa < 5'(CELLS)) ? i_pa : 5'd0;
    assign pb = (i_pb < 5'(CELLS)) ? i_pb : 5'd0;
    assign r1 = row_of(pa);
    assign r2 = row_of(pb);
    assign c1_full = pa - row_base(r1);
    assign c2_full = pb - row_base(r2);
    assign c1 = c1_full[2:0];
    assign c2 = c2_full[2:0];

    always_comb begin
        if (r1 == r2) begin
            o_e1 = row_base(r1) + {2'b00, step5(c1)};
            o_e2 = row_base(r2) + {2'b00, step5(c2)};
        end else if (c1 == c2) begin
            o_e1 = row_base(step5(r1)) + {2'b00, c1};
            o_e2 = row_base(step5(r2)) + {2'b00, c2};
        end else begin
            o_e1 = row_base(r1) + {2'b00, c2};
            o_e2 = row_base(r2) + {2'b00, c1};
        end
    end

endmodule

@@ rtl/playfair_digraph_encryptor.sv @@
// Playfair digraph encryptor, top level: sequencer, text state and output register.
// Depends on pfe_pkg, pfe_square and pfe_pair_map.
//
// Usage: words enter on the i_in_* channel (op, letter) and cipher letters leave on
// the o_out_* channel, both valid/ready. Send key start, key letters, key end, then
// text letters and text end. Each pair of text letters gives two output words; the
// second carries pair_end, and the last word of a text end carries message_end.
// Sequencing: key start, key letter, unpaired text letter and ops without effect
// stay in S_IDLE. Key end enters S_WALK: the alphabet is walked one letter a cycle
// through the single write port of the square. A text word that completes a pair
// runs S_POS_A, S_POS_B, S_POS_W, S_MAP, S_E1, S_E1_W, S_E2, S_E2_W: two position
// and two square reads, one a cycle on the shared read port when not stalled,
// with a mapping stage between; S_E1_W and S_E2_W load the two cipher letters.
// o_in_ready is high only between words. When the receiver stalls, the sequencer
// holds before loading the output register, so no word is lost.
// Reset (i_rst_n low at a clock edge) empties the square and the text state; square
// contents are meaningful only after a key has been loaded.
`timescale 1ns / 1ps

module playfair_digraph_encryptor
    import pfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_op,
    input  logic [4:0] i_letter,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_cipher_letter,
    output logic       o_pair_end,
    output logic       o_message_end
);

    t_state  r_state, n_state;
    t_letter r_prev, n_prev;
    logic    r_prev_valid, n_prev_valid;
    t_letter r_pend, n_pend;
    logic    r_pend_valid, n_pend_valid;
    t_letter r_a, n_a;
    t_letter r_b, n_b;
    logic    r_last, n_last;
    t_letter r_walk, n_walk;
    t_cell   r_pa, n_pa;
    t_cell   r_pb, n_pb;
    t_cell   r_e1, n_e1;
    t_cell   r_e2, n_e2;
    logic    r_out_valid, n_out_valid;
    t_letter r_cipher, n_cipher;
    logic    r_pair_end, n_pair_end;
    logic    r_msg_end, n_msg_end;

    t_sq_req sq_req;
    t_cell   pos_q;
    t_letter sq_q;
    t_cell   map_e1;
    t_cell   map_e2;
    logic    in_acc;
    logic    slot_free;
    logic    letter_ok;
    logic    rep;

    pfe_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_pos_q (pos_q),
        .o_sq_q  (sq_q)
    );

    pfe_pair_map u_pair_map (
        .i_pa (r_pa),
        .i_pb (r_pb),
        .o_e1 (map_e1),
        .o_e2 (map_e2)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;
    assign letter_ok  = i_letter < SPACE_CODE;
    assign rep        = r_prev_valid && (r_prev == i_letter);

    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_a          = r_a;
        n_b          = r_b;
        n_last       = r_last;
        n_walk       = r_walk;
        n_pa         = r_pa;
        n_pb         = r_pb;
        n_e1         = r_e1;
        n_e2         = r_e2;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_cipher     = r_cipher;
        n_pair_end   = r_pair_end;
        n_msg_end    = r_msg_end;
        sq_req       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_op))
                        OP_KEY_START: begin
                            sq_req.clear = 1'b1;
                            n_prev       = '0;
                            n_prev_valid = 1'b0;
                            n_pend       = '0;
                            n_pend_valid = 1'b0;
                        end
                        OP_KEY_LETTER: begin
                            sq_req.put        = letter_ok;
                            sq_req.put_letter = fold_j(i_letter);
                        end
                        OP_KEY_END: begin
                            n_walk  = '0;
                            n_state = S_WALK;
                        end
                        OP_TEXT_LETTER: begin
                            if (letter_ok) begin
                                n_prev       = i_letter;
                                n_prev_valid = 1'b1;
                                if (r_pend_valid) begin
                                    n_a          = r_pend;
                                    n_b          = rep ? LETTER_X : i_letter;
                                    n_last       = 1'b0;
                                    n_pend       = i_letter;
                                    n_pend_valid = rep;
                                    n_state      = S_POS_A;
                                end else if (rep) begin
                                    // inserted X pairs with this letter at once
                                    n_a     = LETTER_X;
                                    n_b     = i_letter;
                                    n_last  = 1'b0;
                                    n_state = S_POS_A;
                                end else begin
                                    n_pend       = i_letter;
                                    n_pend_valid = 1'b1;
                                end
                            end
                        end
                        OP_TEXT_END: begin
                            if (r_pend_valid) begin
                                n_a     = r_pend;
                                n_b     = LETTER_X;
                                n_last  = 1'b1;
                                n_state = S_POS_A;
                            end
                            n_prev       = '0;
                            n_prev_valid = 1'b0;
                            n_pend       = '0;
                            n_pend_valid = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                sq_req.put        = (r_walk != LETTER_J);
                sq_req.put_letter = r_walk;
                n_walk            = r_walk + 5'd1;
                if (r_walk == LAST_LETTER) begin
                    n_state = S_IDLE;
                end
            end
            S_POS_A: begin
                sq_req.rd_addr = fold_j(r_a);
                n_state        = S_POS_B;
            end
            S_POS_B: begin
                sq_req.rd_addr = fold_j(r_b);
                n_pa           = pos_q;
                n_state        = S_POS_W;
            end
            S_POS_W: begin
                n_pb    = pos_q;
                n_state = S_MAP;
            end
            S_MAP: begin
                n_e1    = map_e1;
                n_e2    = map_e2;
                n_state = S_E1;
            end
            S_E1: begin
                sq_req.rd_addr = r_e1;
                n_state        = S_E1_W;
            end
            S_E1_W: begin
                sq_req.rd_addr = r_e1;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_cipher    = sq_q;
                    n_pair_end  = 1'b0;
                    n_msg_end   = 1'b0;
                    n_state     = S_E2;
                end
            end
            S_E2: begin
                sq_req.rd_addr = r_e2;
                n_state        = S_E2_W;
            end
            S_E2_W: begin
                sq_req.rd_addr = r_e2;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_cipher    = sq_q;
                    n_pair_end  = 1'b1;
                    n_msg_end   = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev       <= n_prev;
            r_prev_valid <= n_prev_valid;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_last     <= n_last;
        r_walk     <= n_walk;
        r_pa       <= n_pa;
        r_pb       <= n_pb;
        r_e1       <= n_e1;
        r_e2       <= n_e2;
        r_cipher   <= n_cipher;
        r_pair_end <= n_pair_end;
        r_msg_end  <= n_msg_end;
    end

    assign o_out_valid     = r_out_valid;
    assign o_cipher_letter = r_cipher;
    assign o_pair_end      = r_pair_end;
    assign o_message_end   = r_msg_end;

`ifndef SYNTHESIS
    a_second_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E2_W && slot_free) |=> (o_out_valid && o_pair_end))
        else $error("second cipher letter not presented");

    a_msg_end_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_message_end) |-> o_pair_end)
        else $error("message end off a pair boundary");
`endif

endmodule

@@ bench/playfair_digraph_encryptor_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for playfair_digraph_encryptor: directed key and text words, then
// random key loads, messages and stray words, each cipher word checked against a predictor.
// Depends on rtl/pfe_pkg.sv and the encryptor RTL.

module playfair_digraph_encryptor_tb;
    import pfe_pkg::*;

    localparam logic [2:0]  OP_SPARE_MIN = 3'd5;
    localparam logic [2:0]  OP_SPARE_MAX = 3'd7;
    localparam t_letter     BAD_CODE_MIN = 5'd27;
    localparam t_letter     BAD_CODE_MAX = 5'd31;
    localparam int unsigned WORDS_TOTAL  = 1450;
    localparam int unsigned CALM_FROM    = 1300;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        t_letter letter;
        logic    pair_end;
        logic    message_end;
    } t_cipher_word;

    class cipher_scoreboard;
        t_letter      square[CELLS];
        logic [5:0]   cell_at[ALPHA];
        bit           placed[ALPHA];
        int unsigned  filled;
        t_letter      prev_letter;
        bit           prev_ok;
        t_letter      held_letter;
        bit           held_ok;
        t_cipher_word expected_q[$];
        int unsigned  mismatches;
        int unsigned  letters_checked;
        int unsigned  key_ends;
        int unsigned  messages_closed;

        function new();
            foreach (square[k]) square[k] = '0;
            foreach (cell_at[k]) begin
                cell_at[k] = '0;
                placed[k]  = 1'b0;
            end
            filled          = 0;
            mismatches      = 0;
            letters_checked = 0;
            key_ends        = 0;
            messages_closed = 0;
            clear_text();
        endfunction

        function void clear_text();
            prev_letter = '0;
            prev_ok     = 1'b0;
            held_letter = '0;
            held_ok     = 1'b0;
        endfunction

        function void place(t_letter c);
            if (c >= ALPHA || placed[c] || filled >= CELLS)
                return;
            square[filled] = c;
            cell_at[c]     = filled[5:0];
            placed[c]      = 1'b1;
            filled++;
        endfunction

        function int unsigned cell_of(t_letter c);
            int unsigned p;
            p = cell_at[(c == LETTER_J) ? LETTER_I : c];
            return (p < CELLS) ? p : 0;
        endfunction

        function void encipher(t_letter a, t_letter b, bit last);
            int unsigned pa, pb, r1, c1, r2, c2, e1, e2;
            t_cipher_word w1, w2;
            pa = cell_of(a);
            pb = cell_of(b);
            r1 = pa / SIDE;
            c1 = pa % SIDE;
            r2 = pb / SIDE;
            c2 = pb % SIDE;
            if (r1 == r2) begin
                e1 = r1 * SIDE + (c1 + 1) % SIDE;
                e2 = r2 * SIDE + (c2 + 1) % SIDE;
            end else if (c1 == c2) begin
                e1 = ((r1 + 1) % SIDE) * SIDE + c1;
                e2 = ((r2 + 1) % SIDE) * SIDE + c2;
            end else begin
                e1 = r1 * SIDE + c2;
                e2 = r2 * SIDE + c1;
            end
            w1.letter      = square[e1];
            w1.pair_end    = 1'b0;
            w1.message_end = 1'b0;
            w2.letter      = square[e2];
            w2.pair_end    = 1'b1;
            w2.message_end = last;
            expected_q.push_back(w1);
            expected_q.push_back(w2);
        endfunction

        function void take_letter(t_letter c);
            if (held_ok) begin
                encipher(held_letter, c, 1'b0);
                held_ok = 1'b0;
            end else begin
                held_letter = c;
                held_ok     = 1'b1;
            end
        endfunction

        function void note_input(logic [2:0] op, t_letter letter);
            case (op)
                OP_KEY_START: begin
                    foreach (placed[k]) placed[k] = 1'b0;
                    filled = 0;
                    clear_text();
                end
                OP_KEY_LETTER: begin
                    if (letter < SPACE_CODE)
                        place((letter == LETTER_J) ? LETTER_I : letter);
                end
                OP_KEY_END: begin
                    for (int c = 0; c < ALPHA; c++)
                        if (c != LETTER_J)
                            place(t_letter'(c));
                    key_ends++;
                end
                OP_TEXT_LETTER: begin
                    if (letter < SPACE_CODE) begin
                        // doubled letter: X goes in between
                        if (prev_ok && prev_letter == letter)
                            take_letter(LETTER_X);
                        take_letter(letter);
                        prev_letter = letter;
                        prev_ok     = 1'b1;
                    end
                end
                OP_TEXT_END: begin
                    if (held_ok) begin
                        encipher(held_letter, LETTER_X, 1'b1);
                        messages_closed++;
                    end
                    clear_text();
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_letter letter, logic pair_end, logic message_end);
            t_cipher_word exp;
            letters_checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word: letter %0d pair_end %0b message_end %0b",
                             $realtime, letter, pair_end, message_end);
                return;
            end
            exp = expected_q.pop_front();
            if (exp.letter !== letter || exp.pair_end !== pair_end
                    || exp.message_end !== message_end) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected letter %0d pair_end %0b message_end %0b, got %0d %0b %0b",
                             $realtime, exp.letter, exp.pair_end, exp.message_end,
                             letter, pair_end, message_end);
            end
        endfunction

        function int unsigned waiting();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [2:0] i_op        = '0;
    logic [4:0] i_letter    = '0;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [4:0] o_cipher_letter;
    logic       o_pair_end;
    logic       o_message_end;

    cipher_scoreboard sb = new();
    int unsigned      words_sent   = 0;
    int unsigned      in_idle_pct  = 15;
    int unsigned      out_idle_pct = 10;
    int unsigned      stall_left   = 0;

    playfair_digraph_encryptor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_letter        (i_letter),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cipher_letter (o_cipher_letter),
        .o_pair_end      (o_pair_end),
        .o_message_end   (o_message_end)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // receiver stalls in bursts, each started with percent chance out_idle_pct
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < out_idle_pct) begin
            stall_left  <= $urandom_range(0, 6);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_cipher_letter, o_pair_end, o_message_end);
    end

    function automatic t_letter code_of(input byte ch);
        return t_letter'(ch - "A");
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [4:0] letter);
        int unsigned gap;
        if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_letter   <= letter;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(op, letter);
        words_sent++;
    endtask

    initial begin : stimulus
        int unsigned r, kind, len;
        t_letter     l, last_l;
        bit          have_prev;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: key with fold, repeats and junk codes, then text corner cases
        send_word(OP_KEY_START, '0);
        send_word(OP_KEY_LETTER, code_of("P"));
        send_word(OP_KEY_LETTER, code_of("L"));
        send_word(OP_KEY_LETTER, code_of("A"));
        send_word(OP_KEY_LETTER, code_of("Y"));
        send_word(OP_KEY_LETTER, SPACE_CODE);
        send_word(OP_KEY_LETTER, LETTER_J);
        send_word(OP_KEY_LETTER, LETTER_I);
        send_word(OP_KEY_LETTER, BAD_CODE_MAX);
        send_word(OP_KEY_LETTER, code_of("P"));
        send_word(OP_KEY_END, '0);
        send_word(OP_KEY_LETTER, LAST_LETTER);
        send_word(OP_KEY_END, '1);
        send_word(OP_TEXT_LETTER, code_of("A"));
        send_word(OP_TEXT_LETTER, LAST_LETTER);
        send_word(OP_TEXT_LETTER, code_of("L"));
        send_word(OP_TEXT_LETTER, code_of("L"));
        send_word(OP_TEXT_LETTER, SPACE_CODE);
        send_word(OP_TEXT_LETTER, BAD_CODE_MIN);
        send_word(OP_TEXT_LETTER, LETTER_I);
        send_word(OP_TEXT_LETTER, LETTER_J);
        send_word(OP_TEXT_END, '0);
        send_word(OP_TEXT_END, '0);
        send_word(OP_SPARE_MIN, '1);
        send_word(OP_SPARE_MAX, '0);

        while (words_sent < WORDS_TOTAL) begin
            if (words_sent >= CALM_FROM) begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                in_idle_pct  = 15 * $urandom_range(0, 2);
                out_idle_pct = 8 * $urandom_range(0, 2);
            end
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                send_word(OP_KEY_START, t_letter'($urandom_range(0, 31)));
                len = $urandom_range(0, 12);
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        l = SPACE_CODE;
                    else if (r < 15)
                        l = t_letter'($urandom_range(BAD_CODE_MIN, BAD_CODE_MAX));
                    else if (r < 25)
                        l = $urandom_range(0, 1) ? LETTER_I : LETTER_J;
                    else
                        l = t_letter'($urandom_range(0, LAST_LETTER));
                    send_word(OP_KEY_LETTER, l);
                end
                send_word(OP_KEY_END, t_letter'($urandom_range(0, 31)));
            end else if (kind < 85) begin
                len       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                        : $urandom_range(0, 16);
                have_prev = 1'b0;
                last_l    = '0;
                repeat (len) begin
                    r = $urandom_range(0, 99);
                    if (r < 20 && have_prev)
                        l = last_l;
                    else if (r < 26)
                        l = SPACE_CODE;
                    else if (r < 30)
                        l = t_letter'($urandom_range(BAD_CODE_MIN, BAD_CODE_MAX));
                    else if (r < 38)
                        l = $urandom_range(0, 1) ? LETTER_I : LETTER_J;
                    else
                        l = t_letter'($urandom_range(0, LAST_LETTER));
                    if (l < SPACE_CODE) begin
                        last_l    = l;
                        have_prev = 1'b1;
                    end
                    send_word(OP_TEXT_LETTER, l);
                end
                send_word(OP_TEXT_END, t_letter'($urandom_range(0, 31)));
            end else begin
                // stray words: any op, any code, broken keys
                len = $urandom_range(1, 4);
                repeat (len) begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(3'($urandom_range(OP_SPARE_MIN, OP_SPARE_MAX)),
                                  t_letter'($urandom_range(0, 31)));
                    else
                        send_word(3'($urandom_range(0, 7)), t_letter'($urandom_range(0, 31)));
                end
            end
        end
        i_in_valid <= 1'b0;

        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d input words: %0d key ends, %0d messages closed with padding.",
                 words_sent, sb.key_ends, sb.messages_closed);
        $display("%0d cipher words compared, %0d wrong, %0d still outstanding.",
                 sb.letters_checked, sb.mismatches, sb.waiting());
        if (sb.mismatches == 0 && sb.waiting() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("Timed out with %0d words sent, %0d outstanding.", words_sent, sb.waiting());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pfe_pkg.sv
rtl/pfe_square.sv
rtl/pfe_pair_map.sv
rtl/playfair_digraph_encryptor.sv
bench/playfair_digraph_encryptor_tb.sv
